// ===== rtl/bms_pkg.sv =====
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types, constants and the note frequency ROM of the buzzer melody
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bms_pkg;

  localparam int DVD_W  = 20;   // dividend width of the serial divider
  localparam int DVS_W  = 13;   // divisor width (highest note frequency 7902)
  localparam int PER_W  = 12;
  localparam int DUR_W  = 16;
  localparam int NOTE_W = 6;
  localparam int POS_W  = 7;

  localparam logic [DVD_W-1:0] PERIOD_NUM = 20'd1000000;
  localparam logic [6:0]       LOUD_MAX   = 7'd99;
  localparam logic [6:0]       LOUD_BASE  = 7'd100;
  localparam logic [DUR_W-1:0] CNT_WRAP   = 16'hFFFF;

  // register indexes of the configuration port
  localparam logic CFG_ENABLE   = 1'b0;
  localparam logic CFG_LOUDNESS = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_NOTE,
    S_DIV1,
    S_DIV2,
    S_DEC,
    S_ADV,
    S_ADVRD,
    S_PEND,
    S_PENDRD,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [NOTE_W-1:0] note;
    logic [DUR_W-1:0]  dur;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Note frequency in Hz; rest and unused indexes give 0.
  function automatic logic [DVS_W-1:0] note_freq(input logic [NOTE_W-1:0] idx);
    logic [DVS_W-1:0] f;
    unique case (idx)
      6'd1:  f = 13'd262;  6'd2:  f = 13'd277;  6'd3:  f = 13'd294;
      6'd4:  f = 13'd311;  6'd5:  f = 13'd330;  6'd6:  f = 13'd349;
      6'd7:  f = 13'd370;  6'd8:  f = 13'd392;  6'd9:  f = 13'd415;
      6'd10: f = 13'd440;  6'd11: f = 13'd466;  6'd12: f = 13'd494;
      6'd13: f = 13'd523;  6'd14: f = 13'd554;  6'd15: f = 13'd587;
      6'd16: f = 13'd622;  6'd17: f = 13'd659;  6'd18: f = 13'd698;
      6'd19: f = 13'd740;  6'd20: f = 13'd784;  6'd21: f = 13'd830;
      6'd22: f = 13'd880;  6'd23: f = 13'd932;  6'd24: f = 13'd988;
      6'd25: f = 13'd1047; 6'd26: f = 13'd1109; 6'd27: f = 13'd1175;
      6'd28: f = 13'd1245; 6'd29: f = 13'd1319; 6'd30: f = 13'd1397;
      6'd31: f = 13'd1480; 6'd32: f = 13'd1568; 6'd33: f = 13'd1661;
      6'd34: f = 13'd1760; 6'd35: f = 13'd1865; 6'd36: f = 13'd1976;
      6'd37: f = 13'd2093; 6'd38: f = 13'd2218; 6'd39: f = 13'd2349;
      6'd40: f = 13'd2489; 6'd41: f = 13'd2637; 6'd42: f = 13'd2794;
      6'd43: f = 13'd2960; 6'd44: f = 13'd3136; 6'd45: f = 13'd3322;
      6'd46: f = 13'd3520; 6'd47: f = 13'd3729; 6'd48: f = 13'd3951;
      6'd49: f = 13'd4186; 6'd50: f = 13'd4435; 6'd51: f = 13'd4699;
      6'd52: f = 13'd4978; 6'd53: f = 13'd5274; 6'd54: f = 13'd5588;
      6'd55: f = 13'd5920; 6'd56: f = 13'd6272; 6'd57: f = 13'd6645;
      6'd58: f = 13'd7040; 6'd59: f = 13'd7459; 6'd60: f = 13'd7902;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bms_div.sv =====
// ----------------------------------------------------------------------------
// bms_div
// Restoring serial divider, one quotient bit per cycle. Computes both the
// PWM period and the compare value.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_div
  import bms_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  localparam logic [4:0] LAST_STEP = 5'(DVD_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [4:0]       step_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;
  logic [DVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DVD_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == LAST_STEP) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= req.dividend;
      dvs_r  <= req.divisor;
    end else if (busy_r) begin
      step_r <= step_r + 5'd1;
      rem_r  <= rem_nxt;
      quo_r  <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider restarted while busy");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r))
    else $error("divider done without a finished run");

endmodule

`default_nettype wire

// ===== rtl/bms_table.sv =====
// ----------------------------------------------------------------------------
// bms_table
// Song table: note index and duration per entry, one write and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bms_table
  import bms_pkg::*;
#(
  parameter int MAX_NOTES = 64,
  parameter int ADDR_W    = $clog2(MAX_NOTES)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire entry_t            wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output entry_t                 rdata
);

  entry_t mem [MAX_NOTES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/buzzer_melody_sequencer.sv =====
// ----------------------------------------------------------------------------
// buzzer_melody_sequencer
// Buzzer melody player: song table, 1 ms tick sequencer and a shared serial
// divider for the PWM period and compare values.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  in_*     | in        | tuser: op; tdata: entry_index, note_index, duration,
//           |           |        song_length
//  out_*    | out       | tdata: tone_on, pwm_period, pwm_compare, playing
//  cfg_*    | in        | write-only registers: enable, loudness
//
//  Write, start and unused ops go straight to the response state; a tick
//  that plays a note runs the divider twice (period then compare), a rest
//  skips the divider, and other ticks skip the note states.
//  One item is in flight at a time; in_tready is high only while idle.
//  A finished result waits in the output register while out_tready is low.
//  Reset is synchronous; the song table holds no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module buzzer_melody_sequencer
  import bms_pkg::*;
#(
  parameter int MAX_NOTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // entry_index, note_index, duration, song_length
  input  wire logic [1:0]  in_tuser,   // op
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // tone_on, pwm_period, pwm_compare, playing
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [6:0]  cfg_wdata
);

  localparam int TBL_AW = $clog2(MAX_NOTES);

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [DUR_W-1:0] cnt_r, cnt_nxt;
  logic             play_r, play_nxt;
  logic             pend_r, pend_nxt;
  logic             tone_r, tone_nxt;
  logic [PER_W-1:0] period_r, period_nxt;
  logic [PER_W-1:0] compare_r, compare_nxt;
  logic             enable_r, enable_nxt;
  logic [6:0]       loud_r, loud_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;

  logic [NOTE_W-1:0] in_entry;
  logic [NOTE_W-1:0] in_note;
  logic [DUR_W-1:0]  in_dur;
  logic [POS_W-1:0]  in_len;
  op_t               in_op;

  logic             tbl_we;
  entry_t           tbl_rdata;
  logic [POS_W-1:0] rd_pos;
  logic [POS_W-1:0] pos_inc;
  logic             pos_ok;
  logic             inc_ok;
  logic [6:0]       loud_sat;
  logic [DVS_W-1:0] freq;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign in_entry = in_tdata[5:0];
  assign in_note  = in_tdata[11:6];
  assign in_dur   = in_tdata[27:12];
  assign in_len   = in_tdata[34:28];
  assign in_op    = op_t'(in_tuser);

  assign pos_inc  = pos_r + 7'd1;
  assign pos_ok   = (pos_r < len_r) && (32'(pos_r) < MAX_NOTES);
  assign inc_ok   = (pos_inc < len_r) && (32'(pos_inc) < MAX_NOTES);
  assign loud_sat = (loud_r > LOUD_MAX) ? LOUD_MAX : loud_r;
  assign freq     = note_freq(tbl_rdata.note);

  assign in_tready = (state_r == S_IDLE);
  assign tbl_we    = in_tready && in_tvalid && (in_op == OP_WRITE)
                     && (32'(in_entry) < MAX_NOTES);

  always_comb begin
    unique case (state_r)
      S_ADV:   rd_pos = pos_inc;
      S_PEND:  rd_pos = '0;
      default: rd_pos = pos_r;
    endcase
  end

  bms_table #(
    .MAX_NOTES (MAX_NOTES),
    .ADDR_W    (TBL_AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (TBL_AW'(in_entry)),
    .wdata ({in_note, in_dur}),
    .raddr (TBL_AW'(rd_pos)),
    .rdata (tbl_rdata)
  );

  bms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      play_r      <= 1'b0;
      pend_r      <= 1'b0;
      tone_r      <= 1'b0;
      period_r    <= '0;
      compare_r   <= '0;
      enable_r    <= 1'b1;
      loud_r      <= 7'd98;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      play_r      <= play_nxt;
      pend_r      <= pend_nxt;
      tone_r      <= tone_nxt;
      period_r    <= period_nxt;
      compare_r   <= compare_nxt;
      enable_r    <= enable_nxt;
      loud_r      <= loud_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    play_nxt      = play_r;
    pend_nxt      = pend_r;
    tone_nxt      = tone_r;
    period_nxt    = period_r;
    compare_nxt   = compare_r;
    enable_nxt    = enable_r;
    loud_nxt      = loud_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    div_req       = '0;

    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_ENABLE:   enable_nxt = cfg_wdata[0];
        CFG_LOUDNESS: loud_nxt   = cfg_wdata;
        default:      ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_RESP;
          case (in_op)
            OP_START: begin
              len_nxt  = (32'(in_len) > MAX_NOTES) ? POS_W'(MAX_NOTES) : in_len;
              pos_nxt  = '0;
              pend_nxt = 1'b1;
              tone_nxt = 1'b0;
            end
            OP_TICK:  state_nxt = S_START;
            default:  ;
          endcase
        end
      end
      S_START: begin
        if (play_r && enable_r) begin
          if (pos_ok) begin
            state_nxt = S_NOTE;     // note read is under way
          end else begin
            tone_nxt  = 1'b0;
            play_nxt  = 1'b0;
            state_nxt = S_ADV;
          end
        end else begin
          tone_nxt  = 1'b0;
          state_nxt = S_PEND;
        end
      end
      S_NOTE: begin
        if (freq == '0) begin
          period_nxt  = '0;
          compare_nxt = '0;
          state_nxt   = S_DEC;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = PERIOD_NUM;
          div_req.divisor  = freq;
          state_nxt        = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          period_nxt       = div_rsp.quotient[PER_W-1:0];
          div_req.start    = 1'b1;
          div_req.dividend = DVD_W'(div_rsp.quotient[PER_W-1:0]);
          div_req.divisor  = DVS_W'(LOUD_BASE - loud_sat);
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          compare_nxt = div_rsp.quotient[PER_W-1:0];
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        cnt_nxt   = cnt_r - 16'd1;
        tone_nxt  = 1'b1;
        state_nxt = S_ADV;
      end
      S_ADV: begin
        // countdown wrapped: move to the next entry; load its duration if it is within the song, else clear the count
        if (cnt_r == CNT_WRAP) begin
          pos_nxt = pos_inc;
          if (inc_ok) begin
            state_nxt = S_ADVRD;
          end else begin
            cnt_nxt   = '0;
            state_nxt = S_PEND;
          end
        end else begin
          state_nxt = S_PEND;
        end
      end
      S_ADVRD: begin
        cnt_nxt   = tbl_rdata.dur;
        state_nxt = S_PEND;
      end
      S_PEND: begin
        state_nxt = S_RESP;
        if (pend_r && enable_r) begin
          pend_nxt = 1'b0;
          if (pos_r == '0) begin
            play_nxt = 1'b1;
            if (len_r != '0) begin
              state_nxt = S_PENDRD;
            end else begin
              cnt_nxt = '0;
            end
          end
        end
      end
      S_PENDRD: begin
        cnt_nxt   = tbl_rdata.dur;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'd0, play_r, compare_r, period_r, tone_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_tone_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    tone_r |-> play_r)
    else $error("tone running while not playing");

  a_rest_compare: assert property (@(posedge clk) disable iff (!rst_n)
    (period_r == '0) |-> (compare_r == '0))
    else $error("compare nonzero with a zero period");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result loaded outside the response state");

  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider finished with no waiting state");

endmodule

`default_nettype wire
